// File: sv/trq_pkg.sv
package trq_pkg;

   // Queue geometry and the widths that follow from it.
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int KEEP_W = 8;
   localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

   // Fixed field widths of the transactions.
   localparam int CMD_W = 2;
   localparam int ID_W = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W = 3;
   localparam int COUNT_W = 4;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LIST = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Access to the identifier store.
   typedef struct packed {
      logic wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [ID_W-1:0] wr_data;
      logic rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   // One result transaction.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic has_id;
      logic [ID_W-1:0] id_out;
      logic [SLOT_W-1:0] slot;
      logic [COUNT_W-1:0] count_out;
      logic last;
   } rsp_item_type;

   // Slot that lies off entries behind base, wrapping round the ring.
   // The base stays below the depth and the offset does not exceed it, so one subtraction suffices.
   function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return PTR_W'(sum);
   endfunction

endpackage

// File: sv/truncating_ring_id_queue_unit.sv
// Ring queue of 16-bit identifiers with push, pop, clear and list commands.
// The request channel (req_) carries one command per transaction: the command
// code in req_tuser, the identifier and keep count in req_tdata. The response
// channel (rsp_) returns one transaction for push and pop, one per removed
// entry for clear and one per queued entry for list, with rsp_tlast on the
// final transaction of each command; a clear that removes nothing and a list
// of an empty queue give a single transaction with no identifier.
// Sequence: a request is taken in the idle state and executed in the exec
// state. A push, a pop of an empty queue, a clear that removes nothing and a
// list of an empty queue register their response directly from the exec state.
// Any other pop, clear or list reads the identifier memory through its
// registered read port and then walks the entries in the data state, one
// response per cycle unless the receiver stalls. The next request is taken
// as soon as the sequencer returns to idle, even while a response waits in
// the output register; if the receiver stalls, the sequencer holds before
// loading the next response and no transaction is lost. Reset (synchronous,
// active high) empties the queue and clears the head pointer at once; no
// clearing pass runs and the memory is only read after a push has written it.
module truncating_ring_id_queue_unit
   import trq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,  // ext_id [15:0], keep_count [23:16]
   input  logic [1:0] req_tuser,   // cmd [1:0]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,  // id_out [15:0], slot [18:16], count_out [22:19], zero [23]
   output logic [2:0] rsp_tuser,   // status [1:0], has_id [2]
   output logic rsp_tlast
);

   mem_req_type mem_req;
   logic [ID_W-1:0] rd_data;
   rsp_item_type rsp_item;

   trq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_cmd(req_tuser),
      .req_ext_id(req_tdata[15:0]),
      .req_keep_count(req_tdata[23:16]),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_item(rsp_item),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );

   trq_store u_store (
      .clock(clock),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );

   // Pack the response transaction onto the stream ports.
   assign rsp_tdata = {1'b0, rsp_item.count_out, rsp_item.slot, rsp_item.id_out};
   assign rsp_tuser = {rsp_item.has_id, rsp_item.status};
   assign rsp_tlast = rsp_item.last;

endmodule

// File: sv/trq_store.sv
module trq_store
   import trq_pkg::*;
(
   input  logic clock,
   input  mem_req_type mem_req,
   output logic [ID_W-1:0] rd_data
);

   // Identifier store; contents are undefined until a push writes them.
   logic [ID_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/trq_ctrl.sv
module trq_ctrl
   import trq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic [ID_W-1:0] req_ext_id,
   input  logic [KEEP_W-1:0] req_keep_count,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_item_type rsp_item,
   output mem_req_type mem_req,
   input  logic [ID_W-1:0] rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DATA
   } state_type;

   state_type state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0] ext_id_ff, ext_id_in;
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0] rcount_ff, rcount_in;
   rsp_item_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic out_free;
   logic keep_lt;
   logic [CNT_W-1:0] keep_n;
   logic [CNT_W-1:0] trunc;
   logic [CNT_W-1:0] idx_next;
   logic [PTR_W-1:0] push_pos;

   // The output register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Truncation of the queue to the kept entries.
   assign keep_lt = CMP_W'(keep_ff) < CMP_W'(cnt_ff);
   assign keep_n = CNT_W'(keep_ff);
   assign trunc = keep_lt ? keep_n : cnt_ff;
   assign push_pos = ring_pos(head_ff, trunc);
   assign idx_next = idx_ff + 1'b1;

   // Sequencer. Reads and writes of the store never overlap, since only one
   // command is at work at a time, so no forwarding is needed.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      ext_id_in = ext_id_ff;
      keep_in = keep_ff;
      head_in = head_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      end_in = end_ff;
      rcount_in = rcount_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_req = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               ext_id_in = req_ext_id;
               keep_in = req_keep_count;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               case (cmd_ff)
                  CMD_PUSH: begin
                     state_in = ST_IDLE;
                     rsp_valid_in = 1'b1;
                     if (trunc >= CNT_W'(QUEUE_DEPTH)) begin
                        cnt_in = trunc;
                        rsp_in.status = STATUS_FULL;
                        rsp_in.count_out = COUNT_W'(trunc);
                     end else begin
                        mem_req.wr_en = 1'b1;
                        mem_req.wr_addr = push_pos;
                        mem_req.wr_data = ext_id_ff;
                        cnt_in = trunc + 1'b1;
                        rsp_in.status = STATUS_OK;
                        rsp_in.slot = SLOT_W'(push_pos);
                        rsp_in.count_out = COUNT_W'(trunc + 1'b1);
                     end
                  end

                  CMD_POP: begin
                     if (cnt_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = head_ff;
                        head_in = ring_pos(head_ff, CNT_W'(1));
                        cnt_in = cnt_ff - 1'b1;
                        idx_in = '0;
                        end_in = CNT_W'(1);
                        rcount_in = cnt_ff - 1'b1;
                        state_in = ST_DATA;
                     end
                  end

                  CMD_CLEAR: begin
                     if (!keep_lt) begin
                        rsp_valid_in = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = ring_pos(head_ff, keep_n);
                        idx_in = keep_n;
                        end_in = cnt_ff;
                        rcount_in = cnt_ff - keep_n;
                        cnt_in = keep_n;
                        state_in = ST_DATA;
                     end
                  end

                  CMD_LIST: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = head_ff;
                        idx_in = '0;
                        end_in = cnt_ff;
                        rcount_in = cnt_ff;
                        state_in = ST_DATA;
                     end
                  end

                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_DATA: begin
            // Read data is present; pass it on and fetch the next entry.
            if (out_free) begin
               rsp_in = '0;
               rsp_in.status = STATUS_OK;
               rsp_in.has_id = 1'b1;
               rsp_in.id_out = rd_data;
               rsp_in.count_out = COUNT_W'(rcount_ff);
               rsp_in.last = (idx_next == end_ff);
               rsp_valid_in = 1'b1;
               if (idx_next == end_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_next;
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr = ring_pos(head_ff, idx_next);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      ext_id_ff <= ext_id_in;
      keep_ff <= keep_in;
      idx_ff <= idx_in;
      end_ff <= end_in;
      rcount_ff <= rcount_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   // The count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   // The head always names a real slot.
   assert property (@(posedge clock) disable iff (reset)
      head_ff < PTR_W'(QUEUE_DEPTH - 1) || head_ff == PTR_W'(QUEUE_DEPTH - 1))
      else $error("head pointer outside the ring");

   // The store is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("simultaneous read and write of the store");

   // A walk never runs past its end.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> idx_ff < end_ff)
      else $error("walk index past its end");

   // A result loads only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result overwritten");

endmodule
